FILE: src/modexp_pkg.sv
package modexp_pkg;
    localparam int unsigned VALUE_BITS_DEF = 64;
    localparam int unsigned FIELD_W = 63;
    localparam logic [62:0] DEFAULT_MODULUS = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_NEXT,
        ST_DONE
    } t_state;
endpackage

FILE: src/modular_exponentiation_top.sv
// Modular exponentiation engine, right-to-left square-and-multiply.
//
// Command channel: present i_base, i_exponent, i_modulus and
// i_use_default_modulus with i_start high while o_busy is low; that edge
// accepts the beat. o_busy then stays high until the result is shown.
// Result channel: o_done is high for exactly one cycle with o_power_result
// and o_zero_modulus_error valid. The receiver cannot stall, so the result
// must be taken in that cycle.
//
// A zero or negative exponent, or a zero modulus, goes straight from idle to
// the done state. Otherwise the base is first reduced, then each of the
// SCAN_BITS exponent bits needs one optional multiply and one square,
// each a bit-serial shift-and-add over 63 multiplier bits, plus a set-up
// state (ST_NEXT). The reduction, the multiplies and the squares all share
// one modular multiply-by-one-bit step.
//
// A new command is taken only once the previous result has been shown.
// Reset (synchronous, active low) returns the control to idle and drops
// o_busy and o_done; the datapath registers are not cleared.
module modular_exponentiation_top
    import modexp_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_base,
    input  logic [63:0] i_exponent,
    input  logic [62:0] i_modulus,
    input  logic        i_use_default_modulus,
    output logic        o_busy,
    output logic        o_done,
    output logic [62:0] o_power_result,
    output logic        o_zero_modulus_error
);
    // Number of exponent bits scanned, clamped to the 63 a positive exponent has.
    localparam int unsigned SCAN_BITS = (VALUE_BITS - 1 > 63) ? 63 :
                                        ((VALUE_BITS - 1 < 1) ? 1 : VALUE_BITS - 1);
    localparam logic [5:0] SCAN_LAST = 6'(SCAN_BITS - 1);

    t_state r_state, n_state;

    logic [62:0] r_mod;
    logic [62:0] r_base, n_base;     // running base power
    logic [62:0] r_res, n_res;       // running result
    logic [62:0] r_exp, n_exp;       // exponent, shifted right one bit a step
    logic [5:0]  r_bitn, n_bitn;     // exponent step counter
    logic [62:0] r_acc, n_acc;       // serial product accumulator
    logic [62:0] r_mpl, n_mpl;       // multiplier, shifted left one bit a cycle during a serial multiply
    logic [62:0] r_mcd, n_mcd;       // multiplicand, already reduced
    logic [5:0]  r_cnt, n_cnt;       // bit counter within a serial multiply
    logic        r_err, n_err;
    logic        r_done, n_done;

    // One step of the shift-and-add: acc = 2*acc (+ mcd) mod m, all below m.
    logic [63:0] w_dbl, w_add;
    logic [62:0] w_dbl_red, w_step;

    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_mod}) ? 63'(w_dbl - {1'b0, r_mod}) : w_dbl[62:0];
        w_add     = {1'b0, w_dbl_red} + {1'b0, r_mcd};
        if (r_mpl[62]) begin
            w_step = (w_add >= {1'b0, r_mod}) ? 63'(w_add - {1'b0, r_mod}) : w_add[62:0];
        end else begin
            w_step = w_dbl_red;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && !r_done) begin
                    if (i_exponent[63] || (i_exponent == 64'd0)) begin
                        n_state = ST_DONE;
                    end else if (!i_use_default_modulus && (i_modulus == 63'd0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: if (r_cnt == 6'd62) n_state = ST_MUL;
            ST_MUL: begin
                if (!r_exp[0] || (r_cnt == 6'd62)) n_state = ST_SQR;
            end
            ST_SQR: if (r_cnt == 6'd62) n_state = ST_NEXT;
            ST_NEXT: n_state = (r_bitn == SCAN_LAST) ? ST_DONE : ST_MUL;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_base = r_base;
        n_res  = r_res;
        n_exp  = r_exp;
        n_bitn = r_bitn;
        n_acc  = r_acc;
        n_mpl  = r_mpl;
        n_mcd  = r_mcd;
        n_cnt  = r_cnt;
        n_err  = r_err;
        n_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_res  = 63'd1;
                n_err  = 1'b0;
                n_exp  = i_exponent[62:0];
                n_bitn = 6'd0;
                n_cnt  = 6'd0;
                n_acc  = 63'd0;
                // Reduce the base as base*1: multiplier is base, multiplicand 1.
                n_mpl  = i_base;
                n_mcd  = 63'd1;
                if (i_start && !r_done && !i_exponent[63] && (i_exponent != 64'd0) &&
                    !i_use_default_modulus && (i_modulus == 63'd0)) begin
                    n_err = 1'b1;
                    n_res = 63'd0;
                end
            end
            ST_REDUCE: begin
                n_acc = w_step;
                n_mpl = {r_mpl[61:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd62) begin
                    n_base = w_step;
                    n_cnt  = 6'd0;
                    n_acc  = 63'd0;
                    n_mpl  = r_res;
                    n_mcd  = w_step;
                end
            end
            ST_MUL: begin
                if (!r_exp[0]) begin
                    n_cnt = 6'd0;
                    n_acc = 63'd0;
                    n_mpl = r_base;
                    n_mcd = r_base;
                end else begin
                    n_acc = w_step;
                    n_mpl = {r_mpl[61:0], 1'b0};
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd62) begin
                        n_res = w_step;
                        n_cnt = 6'd0;
                        n_acc = 63'd0;
                        n_mpl = r_base;
                        n_mcd = r_base;
                    end
                end
            end
            ST_SQR: begin
                n_acc = w_step;
                n_mpl = {r_mpl[61:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd62) begin
                    n_base = w_step;
                end
            end
            ST_NEXT: begin
                n_exp  = {1'b0, r_exp[62:1]};
                n_bitn = r_bitn + 6'd1;
                n_cnt  = 6'd0;
                n_acc  = 63'd0;
                n_mpl  = r_res;
                n_mcd  = r_base;
            end
            ST_DONE: n_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start && !r_done) begin
            r_mod <= i_use_default_modulus ? DEFAULT_MODULUS : i_modulus;
        end
        r_base <= n_base;
        r_res  <= n_res;
        r_exp  <= n_exp;
        r_bitn <= n_bitn;
        r_acc  <= n_acc;
        r_mpl  <= n_mpl;
        r_mcd  <= n_mcd;
        r_cnt  <= n_cnt;
        r_err  <= n_err;
    end

    // Outputs: the result registers hold still while o_done is shown.
    always_comb begin
        o_busy               = (r_state != ST_IDLE) || r_done;
        o_done               = r_done;
        o_power_result       = r_res;
        o_zero_modulus_error = r_err;
    end
endmodule
